FILE: hdl/wpps_pkg.sv
package wpps_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int ADDR_W     = (HEAP_DEPTH > 2) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = ADDR_W + 2;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = PROD_W + CNT_W;
    localparam int PEN_W      = 40;
    localparam int PCNT_W     = 9;
    localparam int CMP_W      = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;
    localparam int ENTRY_W    = 32;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARR_ADD,
        ST_UP_RD,
        ST_UP_CMP,
        ST_TK_RD,
        ST_TK_CHK,
        ST_TK_LAST,
        ST_TK_LOAD,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    function automatic logic [15:0] wt_of(input entry_t e);
        return e[15:0];
    endfunction

    function automatic logic [15:0] work_of(input entry_t e);
        return e[31:16];
    endfunction

endpackage

FILE: hdl/weighted_preemptive_priority_scheduler.sv
// Weighted preemptive priority scheduler.
// Input channel (in_valid / in_stall) carries one request: opcode 0 inserts
// a job of job_days work units and weight job_weight into a max-heap held in
// a single-port-write, registered-read memory; opcode 1 serves the heaviest
// job for one unit. Each request yields one result on the output channel
// (out_valid / out_stall): the running penalty sum, the pending job count,
// the served weight and flags for a served job or a dropped arrival.
// One request is in work at a time; in_stall is high until it completes.
// Arrival: the sum takes work times weight; the job climbs from the new last
// slot a level at a time until at the root or below a parent of equal or
// greater weight. Tick: the root loses one unit; on its last unit it is
// removed and the last job, if any, takes its place, sinking past the heavier
// child (left wins ties) while that child outweighs it. Trivial requests
// (zero work, full heap, empty heap) skip the heap memory. The rate is set by
// the one memory read port walked one heap level at a time by the sequencer.
// A result waits in the output register while out_stall is high; the next
// request is still accepted and runs, then holds until the register frees.
// Reset empties the heap and clears the sum; no memory clearing pass is run.
module weighted_preemptive_priority_scheduler
    import wpps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [15:0]       job_days,
    input  logic [15:0]       job_weight,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PEN_W-1:0]  total_penalty,
    output logic [PCNT_W-1:0] pending_count,
    output logic [15:0]       served_weight,
    output logic              served_valid,
    output logic              dropped
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            cur_reg, cur_next;
    entry_t            left_reg, left_next;
    logic [15:0]       sw_reg, sw_next;
    logic              sv_reg, sv_next;
    logic              drop_reg, drop_next;

    logic              out_valid_reg, out_valid_next;
    logic [PEN_W-1:0]  pen_out_reg, pen_out_next;
    logic [PCNT_W-1:0] cnt_out_reg, cnt_out_next;
    logic [15:0]       sw_out_reg, sw_out_next;
    logic              sv_out_reg, sv_out_next;
    logic              drop_out_reg, drop_out_next;

    entry_t            mem [HEAP_DEPTH];
    entry_t            rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;

    logic              accept;
    logic [ADDR_W-1:0] parent;
    logic [IDX_W-1:0]  l_idx, r_idx, cnt_idx;
    logic              l_ok, r_ok;
    logic [15:0]       best_w;
    logic [1:0]        sel;

    assign accept  = in_valid && !in_stall;
    assign parent  = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign l_idx   = IDX_W'({pos_reg, 1'b1});
    assign r_idx   = l_idx + IDX_W'(1);
    assign cnt_idx = IDX_W'(count_reg);
    assign l_ok    = l_idx < cnt_idx;
    assign r_ok    = r_idx < cnt_idx;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        left_reg     <= left_next;
        sw_reg       <= sw_next;
        sv_reg       <= sv_next;
        drop_reg     <= drop_next;
        pen_out_reg  <= pen_out_next;
        cnt_out_reg  <= cnt_out_next;
        sw_out_reg   <= sw_out_next;
        sv_out_reg   <= sv_out_next;
        drop_out_reg <= drop_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        sw_next        = sw_reg;
        sv_next        = sv_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        pen_out_next   = pen_out_reg;
        cnt_out_next   = cnt_out_reg;
        sw_out_next    = sw_out_reg;
        sv_out_next    = sv_out_reg;
        drop_out_next  = drop_out_reg;
        rd_addr        = '0;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = cur_reg;
        best_w         = wt_of(cur_reg);
        sel            = 2'd0;
        in_stall       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sw_next   = '0;
                    sv_next   = 1'b0;
                    drop_next = 1'b0;
                    prod_next = PROD_W'(job_days) * PROD_W'(job_weight);
                    cur_next  = {job_days, job_weight};
                    pos_next  = count_reg[ADDR_W-1:0];
                    state_next = ST_DONE;
                    if (opcode == OP_ARRIVE)
                    begin
                        if (job_days != '0)
                        begin
                            if (count_reg == CNT_W'(HEAP_DEPTH))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_ARR_ADD;
                            end
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = ST_TK_RD;
                    end
                end
            end

            ST_ARR_ADD:
            begin
                sum_next   = sum_reg + SUM_W'(prod_reg);
                state_next = ST_UP_RD;
            end

            ST_UP_RD:
            begin
                rd_addr = parent;
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                we = 1'b1;
                if (wt_of(rd_data) >= wt_of(cur_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    wdata      = rd_data;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end
            end

            ST_TK_RD:
            begin
                rd_addr    = '0;
                state_next = ST_TK_CHK;
            end

            ST_TK_CHK:
            begin
                sw_next  = wt_of(rd_data);
                sv_next  = 1'b1;
                sum_next = sum_reg - SUM_W'(wt_of(rd_data));
                if (work_of(rd_data) > 16'd1)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = {work_of(rd_data) - 16'd1, wt_of(rd_data)};
                    state_next = ST_DONE;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_TK_LAST;
                end
            end

            ST_TK_LAST:
            begin
                rd_addr    = count_reg[ADDR_W-1:0];
                state_next = ST_TK_LOAD;
            end

            ST_TK_LOAD:
            begin
                cur_next   = rd_data;
                pos_next   = '0;
                state_next = ST_DN_RDL;
            end

            ST_DN_RDL:
            begin
                rd_addr = l_idx[ADDR_W-1:0];
                if (!l_ok)
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DN_RDR;
                end
            end

            ST_DN_RDR:
            begin
                rd_addr    = r_idx[ADDR_W-1:0];
                left_next  = rd_data;
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                if (wt_of(left_reg) > best_w)
                begin
                    best_w = wt_of(left_reg);
                    sel    = 2'd1;
                end
                if (r_ok && (wt_of(rd_data) > best_w))
                begin
                    sel = 2'd2;
                end
                we = 1'b1;
                case (sel)
                    2'd1:
                    begin
                        wdata      = left_reg;
                        pos_next   = l_idx[ADDR_W-1:0];
                        state_next = ST_DN_RDL;
                    end
                    2'd2:
                    begin
                        wdata      = rd_data;
                        pos_next   = r_idx[ADDR_W-1:0];
                        state_next = ST_DN_RDL;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    pen_out_next   = (sum_reg > SUM_W'(41'h0FF_FFFF_FFFF)) ?
                                     {PEN_W{1'b1}} : PEN_W'(sum_reg);
                    cnt_out_next   = (CMP_W'(count_reg) > CMP_W'(511)) ?
                                     {PCNT_W{1'b1}} : PCNT_W'(count_reg);
                    sw_out_next    = sw_reg;
                    sv_out_next    = sv_reg;
                    drop_out_next  = drop_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign total_penalty = pen_out_reg;
    assign pending_count = cnt_out_reg;
    assign served_weight = sw_out_reg;
    assign served_valid  = sv_out_reg;
    assign dropped       = drop_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HEAP_DEPTH))
        else $error("job count above heap depth");

    a_sift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_RD || state_reg == ST_UP_CMP || state_reg == ST_DN_RDL ||
         state_reg == ST_DN_RDR || state_reg == ST_DN_CMP)
        |-> (CNT_W'(pos_reg) < count_reg))
        else $error("sift position outside the heap");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(served_valid && dropped))
        else $error("result both served and dropped");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (pending_count != '0))
        else $error("dropped request with an empty heap");

endmodule
